// ===== hdl/ssrg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrg_pkg
// Shared constants, types and rate functions for the speed slope ramp
// generator.
// ----------------------------------------------------------------------------
package ssrg_pkg;

   localparam int LOOP_RATE_HZ  = 16000;
   localparam int TICKS_PER_MS  = LOOP_RATE_HZ / 1000;
   localparam int SPEED_SCALE   = 100;
   localparam int REF_SPEED_RPM = 1000;
   localparam int FULL_SCALE    = SPEED_SCALE * REF_SPEED_RPM;

   localparam int BAND_SHORT_MS = 100;
   localparam int BAND_MID_MS   = 10000;
   localparam int BAND_LONG_MS  = 40000;

   localparam int SPEED_W     = 16;
   localparam int SCALED_W    = 24;
   localparam int SUM_W       = SCALED_W + 1;
   localparam int TIME_W      = 16;
   localparam int STEP_W      = 16;
   localparam int INTERVAL_W  = 8;
   localparam int NUM_W       = 22;
   localparam int DEN_W       = 16;
   localparam int DIV_CNT_W   = $clog2(NUM_W);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLAN_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_TIME = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECEL_TIME = 2'd2;

   localparam int STEP_MAX     = (1 << STEP_W) - 1;
   localparam int INTERVAL_MAX = (1 << INTERVAL_W) - 1;

   function automatic int sat_int(int value, int limit);
      return (value > limit) ? limit : value;
   endfunction

   localparam int INTERVAL_1MS = sat_int(1 * LOOP_RATE_HZ / 1000, INTERVAL_MAX);
   localparam int INTERVAL_4MS = sat_int(4 * LOOP_RATE_HZ / 1000, INTERVAL_MAX);
   localparam int INTERVAL_8MS = sat_int(8 * LOOP_RATE_HZ / 1000, INTERVAL_MAX);

   localparam int RESET_TIME_MS = 100;
   localparam int RESET_TICKS   = RESET_TIME_MS * LOOP_RATE_HZ / 1000;
   localparam int RESET_STEP    =
      sat_int(FULL_SCALE / ((RESET_TICKS == 0) ? 1 : RESET_TICKS), STEP_MAX);

   typedef struct packed {
      logic                  plan_mode;
      logic [STEP_W-1:0]     accel_step;
      logic [STEP_W-1:0]     decel_step;
      logic [INTERVAL_W-1:0] accel_interval;
      logic [INTERVAL_W-1:0] decel_interval;
      logic                  clear_done;
   } rate_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numerator;
      logic [DEN_W-1:0] denominator;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [NUM_W-1:0] rate_numerator(logic [TIME_W-1:0] t);
      if (t <= TIME_W'(BAND_MID_MS)) begin
         return NUM_W'(FULL_SCALE);
      end else if (t <= TIME_W'(BAND_LONG_MS)) begin
         return NUM_W'(4 * FULL_SCALE);
      end else begin
         return NUM_W'(8 * FULL_SCALE);
      end
   endfunction

   function automatic logic [DEN_W-1:0] rate_divisor(logic [TIME_W-1:0] t);
      logic [DEN_W-1:0] d;
      if (t <= TIME_W'(BAND_SHORT_MS)) begin
         d = DEN_W'(t * TICKS_PER_MS);
         if (d == '0) begin
            d = DEN_W'(1);
         end
      end else begin
         d = t;
      end
      return d;
   endfunction

   function automatic logic [INTERVAL_W-1:0] rate_interval(logic [TIME_W-1:0] t);
      if (t <= TIME_W'(BAND_SHORT_MS)) begin
         return '0;
      end else if (t <= TIME_W'(BAND_MID_MS)) begin
         return INTERVAL_W'(INTERVAL_1MS);
      end else if (t <= TIME_W'(BAND_LONG_MS)) begin
         return INTERVAL_W'(INTERVAL_4MS);
      end else begin
         return INTERVAL_W'(INTERVAL_8MS);
      end
   endfunction

   function automatic logic [STEP_W-1:0] sat_step(logic [NUM_W-1:0] q);
      if (q > NUM_W'(STEP_MAX)) begin
         return '1;
      end else begin
         return q[STEP_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/ssrg_serial_divider.sv =====
// ----------------------------------------------------------------------------
// ssrg_serial_divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssrg_serial_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  ssrg_pkg::div_req_type div_req,
   output ssrg_pkg::div_rsp_type div_rsp
);
   import ssrg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     work_ff, work_in;
   logic [DEN_W-1:0]     den_ff, den_in;

   logic [DEN_W:0]       shifted;
   logic [DEN_W+1:0]     diff;
   logic                 fits;

   assign shifted = {rem_ff, work_ff[NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~diff[DEN_W+1];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      work_in  = work_ff;
      den_in   = den_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         work_in  = div_req.numerator;
         den_in   = div_req.denominator;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         work_in = {work_ff[NUM_W-2:0], fits};
         if (count_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// ===== hdl/ssrg_rate_regs.sv =====
// ----------------------------------------------------------------------------
// ssrg_rate_regs
// Configuration registers and the step and interval values derived from the
// acceleration and deceleration times.
// ----------------------------------------------------------------------------
module ssrg_rate_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [ssrg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ssrg_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                              core_idle,
   input  ssrg_pkg::div_rsp_type             div_rsp,
   output ssrg_pkg::div_req_type             div_req,
   output ssrg_pkg::rate_type                rate,
   output logic                              rate_busy
);
   import ssrg_pkg::*;

   logic                  plan_mode_ff, plan_mode_in;
   logic [TIME_W-1:0]     accel_time_ff, accel_time_in;
   logic [TIME_W-1:0]     decel_time_ff, decel_time_in;
   logic [STEP_W-1:0]     accel_step_ff, accel_step_in;
   logic [STEP_W-1:0]     decel_step_ff, decel_step_in;
   logic [INTERVAL_W-1:0] accel_interval_ff, accel_interval_in;
   logic [INTERVAL_W-1:0] decel_interval_ff, decel_interval_in;
   logic                  pend_accel_ff, pend_accel_in;
   logic                  pend_decel_ff, pend_decel_in;
   logic                  wait_ff, wait_in;
   logic                  owner_decel_ff, owner_decel_in;

   logic                  write_accel;
   logic                  write_decel;
   logic                  start;
   logic                  pick_decel;
   logic [TIME_W-1:0]     pick_time;

   assign write_accel = csr_write_enable && (csr_index == CSR_ACCEL_TIME);
   assign write_decel = csr_write_enable && (csr_index == CSR_DECEL_TIME);
   assign pick_decel  = !pend_accel_ff;
   assign pick_time   = pick_decel ? decel_time_ff : accel_time_ff;
   assign start       = !wait_ff && !div_rsp.busy && core_idle
                        && (pend_accel_ff || pend_decel_ff);

   assign div_req.start       = start;
   assign div_req.numerator   = rate_numerator(pick_time);
   assign div_req.denominator = rate_divisor(pick_time);

   always_comb begin
      plan_mode_in      = plan_mode_ff;
      accel_time_in     = accel_time_ff;
      decel_time_in     = decel_time_ff;
      accel_step_in     = accel_step_ff;
      decel_step_in     = decel_step_ff;
      accel_interval_in = accel_interval_ff;
      decel_interval_in = decel_interval_ff;
      pend_accel_in     = pend_accel_ff;
      pend_decel_in     = pend_decel_ff;
      wait_in           = wait_ff;
      owner_decel_in    = owner_decel_ff;

      if (wait_ff && div_rsp.done) begin
         wait_in = 1'b0;
         if (owner_decel_ff) begin
            decel_step_in = sat_step(div_rsp.quotient);
         end else begin
            accel_step_in = sat_step(div_rsp.quotient);
         end
      end

      if (start) begin
         wait_in        = 1'b1;
         owner_decel_in = pick_decel;
         if (pick_decel) begin
            pend_decel_in = 1'b0;
         end else begin
            pend_accel_in = 1'b0;
         end
      end

      if (csr_write_enable && (csr_index == CSR_PLAN_MODE)) begin
         plan_mode_in = csr_write_data[0];
      end
      if (write_accel) begin
         accel_time_in     = csr_write_data;
         accel_interval_in = rate_interval(csr_write_data);
         pend_accel_in     = 1'b1;
      end
      if (write_decel) begin
         decel_time_in     = csr_write_data;
         decel_interval_in = rate_interval(csr_write_data);
         pend_decel_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_mode_ff      <= 1'b0;
         accel_time_ff     <= TIME_W'(RESET_TIME_MS);
         decel_time_ff     <= TIME_W'(RESET_TIME_MS);
         accel_step_ff     <= STEP_W'(RESET_STEP);
         decel_step_ff     <= STEP_W'(RESET_STEP);
         accel_interval_ff <= rate_interval(TIME_W'(RESET_TIME_MS));
         decel_interval_ff <= rate_interval(TIME_W'(RESET_TIME_MS));
         pend_accel_ff     <= 1'b0;
         pend_decel_ff     <= 1'b0;
         wait_ff           <= 1'b0;
         owner_decel_ff    <= 1'b0;
      end else begin
         plan_mode_ff      <= plan_mode_in;
         accel_time_ff     <= accel_time_in;
         decel_time_ff     <= decel_time_in;
         accel_step_ff     <= accel_step_in;
         decel_step_ff     <= decel_step_in;
         accel_interval_ff <= accel_interval_in;
         decel_interval_ff <= decel_interval_in;
         pend_accel_ff     <= pend_accel_in;
         pend_decel_ff     <= pend_decel_in;
         wait_ff           <= wait_in;
         owner_decel_ff    <= owner_decel_in;
      end
   end

   assign rate.plan_mode      = plan_mode_ff;
   assign rate.accel_step     = accel_step_ff;
   assign rate.decel_step     = decel_step_ff;
   assign rate.accel_interval = accel_interval_ff;
   assign rate.decel_interval = decel_interval_ff;
   assign rate.clear_done     = write_accel || write_decel;

   assign rate_busy = pend_accel_ff || pend_decel_ff || wait_ff;

endmodule

// ===== hdl/ssrg_ramp_core.sv =====
// ----------------------------------------------------------------------------
// ssrg_ramp_core
// Per-tick ramp sequencer: takes a word, steps the scaled speed when a step is due,
// divides it back to rpm on the shared divider and presents the result word.
// ----------------------------------------------------------------------------
module ssrg_ramp_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_drive_enable,
   input  logic signed [ssrg_pkg::SPEED_W-1:0] req_target_speed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ssrg_pkg::SPEED_W-1:0] rsp_speed_command,
   output logic                                rsp_ramp_done,
   input  ssrg_pkg::rate_type                  rate,
   input  logic                                rate_busy,
   input  ssrg_pkg::div_rsp_type               div_rsp,
   output ssrg_pkg::div_req_type               div_req,
   output logic                                core_idle
);
   import ssrg_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADD   = 3'd1;
   localparam logic [2:0] ST_CLAMP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic signed [SCALED_W-1:0]   scaled_ff, scaled_in;
   logic signed [SPEED_W-1:0]    planned_ff, planned_in;
   logic signed [SPEED_W-1:0]    latched_ff, latched_in;
   logic [INTERVAL_W-1:0]        countdown_ff, countdown_in;
   logic                         finished_ff, finished_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         up_ff, up_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [SCALED_W-1:0]   limit_ff, limit_in;
   logic                         neg_ff, neg_in;
   logic signed [SPEED_W-1:0]    res_speed_ff, res_speed_in;
   logic                         res_done_ff, res_done_in;
   logic signed [SPEED_W-1:0]    rsp_speed_ff, rsp_speed_in;
   logic                         rsp_done_ff, rsp_done_in;

   logic                         accept;
   logic                         fin;
   logic [INTERVAL_W-1:0]        cnt_next;
   logic                         use_acc;
   logic signed [SUM_W-1:0]      step_ext;
   logic signed [SUM_W-1:0]      limit_ext;
   logic signed [SUM_W-1:0]      clamped;
   logic [SUM_W-1:0]             mag;
   logic [SPEED_W-1:0]           quot;

   assign core_idle = (state_ff == ST_IDLE);
   assign req_ready = core_idle && !rate_busy;
   assign accept    = req_valid && req_ready;

   assign step_ext  = signed'({{(SUM_W - STEP_W){1'b0}}, step_ff});
   assign limit_ext = SUM_W'(limit_ff);
   assign quot      = div_rsp.quotient[SPEED_W-1:0];

   always_comb begin
      state_in      = state_ff;
      scaled_in     = scaled_ff;
      planned_in    = planned_ff;
      latched_in    = latched_ff;
      countdown_in  = countdown_ff;
      finished_in   = finished_ff;
      rsp_valid_in  = rsp_valid_ff;
      up_in         = up_ff;
      step_in       = step_ff;
      sum_in        = sum_ff;
      limit_in      = limit_ff;
      neg_in        = neg_ff;
      res_speed_in  = res_speed_ff;
      res_done_in   = res_done_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_done_in   = rsp_done_ff;
      fin           = 1'b0;
      cnt_next      = '0;
      use_acc       = 1'b0;
      clamped       = sum_ff;
      mag           = '0;
      div_req.start       = 1'b0;
      div_req.numerator   = '0;
      div_req.denominator = DEN_W'(SPEED_SCALE);

      if (rate.clear_done) begin
         finished_in = 1'b0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_OUT;
               if (!req_drive_enable) begin
                  scaled_in    = '0;
                  planned_in   = '0;
                  latched_in   = '0;
                  countdown_in = '0;
                  finished_in  = 1'b0;
                  res_speed_in = '0;
                  res_done_in  = 1'b0;
               end else if (!rate.plan_mode) begin
                  res_speed_in = req_target_speed;
                  res_done_in  = 1'b1;
               end else begin
                  latched_in   = req_target_speed;
                  fin          = (req_target_speed != latched_ff) ? 1'b0 : finished_ff;
                  finished_in  = fin;
                  res_speed_in = planned_ff;
                  res_done_in  = fin;
                  if (!fin) begin
                     cnt_next     = (countdown_ff == '0) ? '0 : countdown_ff - 1'b1;
                     countdown_in = cnt_next;
                     if (cnt_next == '0) begin
                        if (req_target_speed > planned_ff) begin
                           use_acc      = !req_target_speed[SPEED_W-1]
                                          && (req_target_speed != '0)
                                          && !planned_ff[SPEED_W-1];
                           up_in        = 1'b1;
                           countdown_in = use_acc ? rate.accel_interval : rate.decel_interval;
                           step_in      = use_acc ? rate.accel_step : rate.decel_step;
                           state_in     = ST_ADD;
                        end else if (req_target_speed < planned_ff) begin
                           use_acc      = req_target_speed[SPEED_W-1]
                                          && (planned_ff[SPEED_W-1] || (planned_ff == '0));
                           up_in        = 1'b0;
                           countdown_in = use_acc ? rate.accel_interval : rate.decel_interval;
                           step_in      = use_acc ? rate.accel_step : rate.decel_step;
                           state_in     = ST_ADD;
                        end else begin
                           finished_in = 1'b1;
                           res_done_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         ST_ADD: begin
            sum_in   = up_ff ? (SUM_W'(scaled_ff) + step_ext) : (SUM_W'(scaled_ff) - step_ext);
            limit_in = SCALED_W'(latched_ff * SPEED_SCALE);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (up_ff) begin
               clamped = (sum_ff > limit_ext) ? limit_ext : sum_ff;
            end else begin
               clamped = (sum_ff < limit_ext) ? limit_ext : sum_ff;
            end
            mag               = clamped[SUM_W-1] ? (~clamped + 1'b1) : clamped;
            scaled_in         = SCALED_W'(clamped);
            neg_in            = clamped[SUM_W-1];
            div_req.start     = 1'b1;
            div_req.numerator = NUM_W'(mag);
            state_in          = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               planned_in   = signed'(neg_ff ? (~quot + 1'b1) : quot);
               res_speed_in = planned_in;
               res_done_in  = 1'b0;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = res_speed_ff;
               rsp_done_in  = res_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scaled_ff    <= '0;
         planned_ff   <= '0;
         latched_ff   <= '0;
         countdown_ff <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scaled_ff    <= scaled_in;
         planned_ff   <= planned_in;
         latched_ff   <= latched_in;
         countdown_ff <= countdown_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff        <= up_in;
      step_ff      <= step_in;
      sum_ff       <= sum_in;
      limit_ff     <= limit_in;
      neg_ff       <= neg_in;
      res_speed_ff <= res_speed_in;
      res_done_ff  <= res_done_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_command = rsp_speed_ff;
   assign rsp_ramp_done     = rsp_done_ff;

   a_done_at_target : assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> (planned_ff == latched_ff))
      else $error("ramp marked finished away from the latched target");

   a_busy_not_ready : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request ready while a tick is in progress");

   a_div_owned : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on a divider that is not running");

endmodule

// ===== hdl/speed_slope_ramp_generator_top.sv =====
// ----------------------------------------------------------------------------
// speed_slope_ramp_generator_top
// Linear speed ramp generator for a speed loop, with a bit-serial divider
// shared between the rate setup and the per-tick rescale.
//
//   Channel  Direction  Handshake                    Word
//   req_     in         req_valid / req_ready        drive_enable, target_speed
//   rsp_     out        rsp_valid / rsp_ready        speed_command, ramp_done
//   csr_     in         csr_write_enable             csr_index, csr_write_data
//
// A tick that takes a ramp step passes the add and clamp states and the serial
// divider that rescales the speed by 100, plus the output transfer. Other ticks
// go straight from the idle state to the output transfer.
// A write to a time register occupies the divider, and req_ready stays low
// until the new step is stored.
// A result word waits in the output register while the next word is taken.
// Reset is synchronous and restores the control registers to their reset values.
// ----------------------------------------------------------------------------
module speed_slope_ramp_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_drive_enable,
   input  logic signed [ssrg_pkg::SPEED_W-1:0] req_target_speed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ssrg_pkg::SPEED_W-1:0] rsp_speed_command,
   output logic                                rsp_ramp_done,
   input  logic                                csr_write_enable,
   input  logic [ssrg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssrg_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import ssrg_pkg::*;

   rate_type    rate;
   logic        rate_busy;
   logic        core_idle;
   div_req_type core_div_req;
   div_req_type rate_div_req;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign div_req = core_div_req.start ? core_div_req : rate_div_req;

   ssrg_serial_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ssrg_rate_regs u_rate_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .core_idle        (core_idle),
      .div_rsp          (div_rsp),
      .div_req          (rate_div_req),
      .rate             (rate),
      .rate_busy        (rate_busy)
   );

   ssrg_ramp_core u_ramp_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_drive_enable  (req_drive_enable),
      .req_target_speed  (req_target_speed),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_speed_command (rsp_speed_command),
      .rsp_ramp_done     (rsp_ramp_done),
      .rate              (rate),
      .rate_busy         (rate_busy),
      .div_rsp           (div_rsp),
      .div_req           (core_div_req),
      .core_idle         (core_idle)
   );

endmodule
